// File: sv/svpbs_pkg.sv
// ----------------------------------------------------------------------------
// svpbs_pkg
// Shared types and constants of the slack/value packet buffer scheduler.
// ----------------------------------------------------------------------------
package svpbs_pkg;

  typedef enum logic {
    POL_EDF   = 1'b0,
    POL_VALUE = 1'b1
  } policy_e;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic REG_POLICY   = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  localparam int CapBits   = 5;
  localparam int DropBits  = 5;
  localparam int CountBits = 32;
  localparam int CopyBits  = 4;

  localparam logic [CapBits-1:0]  CAP_RESET = 5'd16;
  localparam logic [DropBits-1:0] DROP_MAX  = 5'd31;

endpackage

// File: sv/svpbs_keycmp.sv
// ----------------------------------------------------------------------------
// svpbs_keycmp
// Shared key comparator: key a is strictly less than key b under the policy.
// ----------------------------------------------------------------------------
module svpbs_keycmp import svpbs_pkg::*; #(
  parameter int SlackBits = 8,
  parameter int ValueBits = 16
) (
  input  policy_e              policy_i,
  input  logic [SlackBits-1:0] a_slack_i,
  input  logic [ValueBits-1:0] a_value_i,
  input  logic [SlackBits-1:0] b_slack_i,
  input  logic [ValueBits-1:0] b_value_i,
  output logic                 less_o
);

  logic slack_lt, slack_eq, value_lt, value_eq;

  assign slack_lt = a_slack_i < b_slack_i;
  assign slack_eq = a_slack_i == b_slack_i;
  assign value_lt = a_value_i < b_value_i;
  assign value_eq = a_value_i == b_value_i;

  // edf orders by (slack, value), value policy by (value, slack)
  always_comb begin
    unique case (policy_i)
      POL_EDF:   less_o = slack_lt || (slack_eq && value_lt);
      POL_VALUE: less_o = value_lt || (value_eq && slack_lt);
      default:   less_o = 1'b0;
    endcase
  end

endmodule

// File: sv/slack_value_packet_buffer_scheduler.sv
// ----------------------------------------------------------------------------
// slack_value_packet_buffer_scheduler
// Bounded packet buffer with edf or greatest-value scheduling and eviction.
// ----------------------------------------------------------------------------
// channel   dir  ports                                          transfer
// command   in   start_i, command_i, copies_i, slack_i, value_i start_i && !busy_o
// result    out  done_o, sent_o, sent_value_o, drops_now_o,    done_o (one cycle)
//                total_arrived/dropped/sent/value_o
// config    in   cfg_we_i, cfg_idx_i, cfg_data_i                cfg_we_i
//
// arrival: per copy, a zero-slack packet is dropped in the arrive state when there is room, a
// free-slot search over the valid bits follows when there is room, or, when full,
// a victim scan through the slot memory's single read port and the comparator,
// then the eviction decision.
// tick: one decrement/expire/select pass plus the send.
// busy_o stays high from the transfer up to the result strobe cycle.
// reset clears the valid bits at once; no clearing pass. results cannot stall.
// ----------------------------------------------------------------------------
module slack_value_packet_buffer_scheduler import svpbs_pkg::*; #(
  parameter int BUFFER_DEPTH = 16,
  parameter int SLACK_BITS   = 8,
  parameter int VALUE_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  command_i,
  input  logic [CopyBits-1:0]   copies_i,
  input  logic [SLACK_BITS-1:0] slack_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CapBits-1:0]    cfg_data_i,
  output logic                  done_o,
  output logic                  sent_o,
  output logic [VALUE_BITS-1:0] sent_value_o,
  output logic [DropBits-1:0]   drops_now_o,
  output logic [CountBits-1:0]  total_arrived_o,
  output logic [CountBits-1:0]  total_dropped_o,
  output logic [CountBits-1:0]  total_sent_o,
  output logic [CountBits-1:0]  total_value_o
);

  localparam int IdxW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CntW = $clog2(BUFFER_DEPTH + 1);
  localparam int OccW = CntW;
  localparam int CmpW = (OccW > CapBits) ? OccW : CapBits;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_FREE,
    ST_VSCAN,
    ST_VICTIM,
    ST_TSCAN,
    ST_TSEND
  } state_e;

  state_e                  state_q, state_d;
  policy_e                 policy_q, policy_d;
  logic [CapBits-1:0]      cap_q, cap_d;
  logic [CopyBits-1:0]     copies_q, copies_d;
  logic [SLACK_BITS-1:0]   in_slack_q, in_slack_d;
  logic [VALUE_BITS-1:0]   in_value_q, in_value_d;
  logic [BUFFER_DEPTH-1:0] valid_q, valid_d;
  logic [OccW-1:0]         occ_q, occ_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [IdxW-1:0]         pidx_q, pidx_d;
  logic [IdxW-1:0]         fidx_q, fidx_d;
  logic                    best_vld_q, best_vld_d;
  logic [IdxW-1:0]         best_idx_q, best_idx_d;
  logic [SLACK_BITS-1:0]   best_slack_q, best_slack_d;
  logic [VALUE_BITS-1:0]   best_value_q, best_value_d;
  logic [CountBits-1:0]    arrived_q, arrived_d;
  logic [CountBits-1:0]    dropped_q, dropped_d;
  logic [CountBits-1:0]    sent_cnt_q, sent_cnt_d;
  logic [CountBits-1:0]    vsum_q, vsum_d;
  logic [DropBits-1:0]     drops_q, drops_d;
  logic                    done_q, done_d;
  logic                    sent_q, sent_d;
  logic [VALUE_BITS-1:0]   sent_val_q, sent_val_d;

  // slot memory, one read and one write port, registered read
  logic [SLACK_BITS-1:0] slack_mem [BUFFER_DEPTH];
  logic [VALUE_BITS-1:0] value_mem [BUFFER_DEPTH];
  logic [SLACK_BITS-1:0] rd_slack_q;
  logic [VALUE_BITS-1:0] rd_value_q;
  logic                  rd_en;
  logic                  mem_we;
  logic [IdxW-1:0]       mem_waddr;
  logic [SLACK_BITS-1:0] mem_wslack;
  logic [VALUE_BITS-1:0] mem_wvalue;

  logic                  room;
  logic                  replace;
  logic                  drop_inc;
  logic                  want_max;
  logic [SLACK_BITS-1:0] cand_slack;
  logic [SLACK_BITS-1:0] a_slack, b_slack;
  logic [VALUE_BITS-1:0] a_value, b_value;
  logic                  key_less;
  logic                  better;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slack_mem[mem_waddr] <= mem_wslack;
      value_mem[mem_waddr] <= mem_wvalue;
    end
    if (rd_en) begin
      rd_slack_q <= slack_mem[cnt_q[IdxW-1:0]];
      rd_value_q <= value_mem[cnt_q[IdxW-1:0]];
    end
  end

  // during a tick pass the candidate is ranked on its decremented slack
  assign cand_slack = (state_q == ST_TSCAN) ? rd_slack_q - SLACK_BITS'(1) : rd_slack_q;
  assign want_max   = (state_q == ST_TSCAN) && (policy_q == POL_VALUE);
  assign a_slack    = want_max ? best_slack_q : cand_slack;
  assign a_value    = want_max ? best_value_q : rd_value_q;
  assign b_slack    = want_max ? cand_slack   : best_slack_q;
  assign b_value    = want_max ? rd_value_q   : best_value_q;

  svpbs_keycmp #(
    .SlackBits(SLACK_BITS),
    .ValueBits(VALUE_BITS)
  ) u_keycmp (
    .policy_i (policy_q),
    .a_slack_i(a_slack),
    .a_value_i(a_value),
    .b_slack_i(b_slack),
    .b_value_i(b_value),
    .less_o   (key_less)
  );

  assign better  = !best_vld_q || key_less;
  assign room    = (CmpW'(occ_q) < CmpW'(cap_q)) && (occ_q < OccW'(BUFFER_DEPTH));
  assign replace = (policy_q == POL_EDF) ? (best_slack_q < in_slack_q)
                                         : (best_value_q < in_value_q);

  always_comb begin
    state_d      = state_q;
    policy_d     = policy_q;
    cap_d        = cap_q;
    copies_d     = copies_q;
    in_slack_d   = in_slack_q;
    in_value_d   = in_value_q;
    valid_d      = valid_q;
    occ_d        = occ_q;
    cnt_d        = cnt_q;
    pidx_d       = pidx_q;
    fidx_d       = fidx_q;
    best_vld_d   = best_vld_q;
    best_idx_d   = best_idx_q;
    best_slack_d = best_slack_q;
    best_value_d = best_value_q;
    arrived_d    = arrived_q;
    dropped_d    = dropped_q;
    sent_cnt_d   = sent_cnt_q;
    vsum_d       = vsum_q;
    drops_d      = drops_q;
    done_d       = 1'b0;
    sent_d       = sent_q;
    sent_val_d   = sent_val_q;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = fidx_q;
    mem_wslack   = in_slack_q;
    mem_wvalue   = in_value_q;
    drop_inc     = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLICY:   policy_d = policy_e'(cfg_data_i[0]);
        REG_CAPACITY: cap_d    = cfg_data_i;
        default:      ;
      endcase
    end

    unique case (state_q) inside
      ST_IDLE: begin
        if (start_i) begin
          copies_d   = copies_i;
          in_slack_d = slack_i;
          in_value_d = value_i;
          drops_d    = '0;
          cnt_d      = '0;
          best_vld_d = 1'b0;
          state_d    = (command_i == CMD_TICK) ? ST_TSCAN : ST_ARRIVE;
        end
      end
      ST_ARRIVE: begin
        if (copies_q == '0) begin
          done_d     = 1'b1;
          sent_d     = 1'b0;
          sent_val_d = '0;
          state_d    = ST_IDLE;
        end else begin
          copies_d  = copies_q - CopyBits'(1);
          arrived_d = arrived_q + CountBits'(1);
          if (room) begin
            if (in_slack_q == '0) begin
              drop_inc = 1'b1;
            end else begin
              fidx_d  = '0;
              state_d = ST_FREE;
            end
          end else begin
            cnt_d      = '0;
            best_vld_d = 1'b0;
            state_d    = ST_VSCAN;
          end
        end
      end
      ST_FREE: begin
        // a free slot exists whenever there is room
        if (!valid_q[fidx_q]) begin
          mem_we           = 1'b1;
          valid_d[fidx_q]  = 1'b1;
          occ_d            = occ_q + OccW'(1);
          state_d          = ST_ARRIVE;
        end else begin
          fidx_d = fidx_q + IdxW'(1);
        end
      end
      ST_VSCAN, ST_TSCAN: begin
        // read slot cnt while the slot read last cycle is ranked
        rd_en  = cnt_q < CntW'(BUFFER_DEPTH);
        cnt_d  = cnt_q + CntW'(1);
        pidx_d = cnt_q[IdxW-1:0];
        if ((cnt_q != '0) && valid_q[pidx_q]) begin
          if ((state_q == ST_TSCAN) && (rd_slack_q <= SLACK_BITS'(1))) begin
            valid_d[pidx_q] = 1'b0;
            occ_d           = occ_q - OccW'(1);
            drop_inc        = 1'b1;
          end else begin
            if (state_q == ST_TSCAN) begin
              mem_we     = 1'b1;
              mem_waddr  = pidx_q;
              mem_wslack = cand_slack;
              mem_wvalue = rd_value_q;
            end
            if (better) begin
              best_vld_d   = 1'b1;
              best_idx_d   = pidx_q;
              best_slack_d = cand_slack;
              best_value_d = rd_value_q;
            end
          end
        end
        if (cnt_q == CntW'(BUFFER_DEPTH)) begin
          state_d = (state_q == ST_TSCAN) ? ST_TSEND : ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        // either the victim or the new packet is lost
        drop_inc = 1'b1;
        if (best_vld_q && replace) begin
          mem_we    = 1'b1;
          mem_waddr = best_idx_q;
        end
        state_d = ST_ARRIVE;
      end
      ST_TSEND: begin
        done_d     = 1'b1;
        sent_d     = best_vld_q;
        sent_val_d = best_vld_q ? best_value_q : '0;
        if (best_vld_q) begin
          valid_d[best_idx_q] = 1'b0;
          occ_d               = occ_q - OccW'(1);
          sent_cnt_d          = sent_cnt_q + CountBits'(1);
          vsum_d              = vsum_q + CountBits'(best_value_q);
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (drop_inc) begin
      dropped_d = dropped_q + CountBits'(1);
      drops_d   = (drops_q == DROP_MAX) ? drops_q : drops_q + DropBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      policy_q     <= POL_EDF;
      cap_q        <= CAP_RESET;
      copies_q     <= '0;
      in_slack_q   <= '0;
      in_value_q   <= '0;
      valid_q      <= '0;
      occ_q        <= '0;
      cnt_q        <= '0;
      pidx_q       <= '0;
      fidx_q       <= '0;
      best_vld_q   <= 1'b0;
      best_idx_q   <= '0;
      best_slack_q <= '0;
      best_value_q <= '0;
      arrived_q    <= '0;
      dropped_q    <= '0;
      sent_cnt_q   <= '0;
      vsum_q       <= '0;
      drops_q      <= '0;
      done_q       <= 1'b0;
      sent_q       <= 1'b0;
      sent_val_q   <= '0;
    end else begin
      state_q      <= state_d;
      policy_q     <= policy_d;
      cap_q        <= cap_d;
      copies_q     <= copies_d;
      in_slack_q   <= in_slack_d;
      in_value_q   <= in_value_d;
      valid_q      <= valid_d;
      occ_q        <= occ_d;
      cnt_q        <= cnt_d;
      pidx_q       <= pidx_d;
      fidx_q       <= fidx_d;
      best_vld_q   <= best_vld_d;
      best_idx_q   <= best_idx_d;
      best_slack_q <= best_slack_d;
      best_value_q <= best_value_d;
      arrived_q    <= arrived_d;
      dropped_q    <= dropped_d;
      sent_cnt_q   <= sent_cnt_d;
      vsum_q       <= vsum_d;
      drops_q      <= drops_d;
      done_q       <= done_d;
      sent_q       <= sent_d;
      sent_val_q   <= sent_val_d;
    end
  end

  assign busy_o          = state_q != ST_IDLE;
  assign done_o          = done_q;
  assign sent_o          = sent_q;
  assign sent_value_o    = sent_val_q;
  assign drops_now_o     = drops_q;
  assign total_arrived_o = arrived_q;
  assign total_dropped_o = dropped_q;
  assign total_sent_o    = sent_cnt_q;
  assign total_value_o   = vsum_q;

  // occupancy counter tracks the valid bits
  a_occ_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OccW'($countones(valid_q)))
    else $error("occupancy counter out of step with valid bits");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(BUFFER_DEPTH))
    else $error("occupancy above buffer depth");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transfer accepted but block not busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (!busy_o && $past(busy_o)))
    else $error("result strobe outside the end of an item");

  a_sent_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_o && done_o |-> total_sent_o == $past(total_sent_o) + CountBits'(1))
    else $error("sent count not advanced with a sent packet");

endmodule
